// ===== rtl/core/ird_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_pkg
// Shared constants, codes and queue entry type of the IR distance converter.
// ----------------------------------------------------------------------------
package ird_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	localparam logic [2:0] SEL_THR_FL     = 3'd0;
	localparam logic [2:0] SEL_THR_FR     = 3'd1;
	localparam logic [2:0] SEL_THR_SR     = 3'd2;
	localparam logic [2:0] SEL_THR_SL     = 3'd3;
	localparam logic [2:0] SEL_DIST_FRONT = 3'd4;
	localparam logic [2:0] SEL_DIST_SIDE  = 3'd5;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOSEG = 1'b1;

	typedef enum logic [1:0] {
		KIND_WR_THR,
		KIND_WR_DIST,
		KIND_CONVERT,
		KIND_IGNORE
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [2:0]   table_select;
		logic [3:0]   entry_index;
		logic [15:0]  entry_value;
		logic [1:0]   sensor;
		logic [12:0]  reading;
	} entry_t;

endpackage

// ===== rtl/core/ird_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_front
// Input handshake and classification of incoming transactions into queue
// entries; writes to nonexistent tables or entries are dropped here.
// ----------------------------------------------------------------------------
module ird_front #(
	parameter int TABLE_DEPTH = ird_pkg::TABLE_DEPTH_DEF
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [2:0]        table_select,
	input  logic [3:0]        entry_index,
	input  logic [15:0]       entry_value,
	input  logic [1:0]        sensor,
	input  logic [12:0]       reading,
	input  logic              full,
	output logic              push,
	output ird_pkg::entry_t   push_data
);
	import ird_pkg::*;

	kind_t kind;

	always_comb begin
		kind = KIND_IGNORE;
		if (operation == OP_CONVERT) begin
			kind = KIND_CONVERT;
		end else if (int'(entry_index) < TABLE_DEPTH) begin
			unique case (table_select) inside
				SEL_THR_FL, SEL_THR_FR, SEL_THR_SR, SEL_THR_SL: kind = KIND_WR_THR;
				SEL_DIST_FRONT, SEL_DIST_SIDE:                  kind = KIND_WR_DIST;
				default:                                        kind = KIND_IGNORE;
			endcase
		end
	end

	assign in_ready = !full;
	assign push     = in_valid && in_ready && (kind != KIND_IGNORE);

	assign push_data.kind         = kind;
	assign push_data.table_select = table_select;
	assign push_data.entry_index  = entry_index;
	assign push_data.entry_value  = entry_value;
	assign push_data.sensor       = sensor;
	assign push_data.reading      = reading;

endmodule

// ===== rtl/core/ird_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_fifo
// Short queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module ird_fifo #(
	parameter int DEPTH = ird_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ird_pkg::entry_t   push_data,
	output logic              full,
	input  logic              pop,
	output ird_pkg::entry_t   pop_data,
	output logic              empty
);
	import ird_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNW-1:0]  count_q;

	assign full     = (count_q == CNW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");

endmodule

// ===== rtl/core/ird_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_div
// Restoring divider, one quotient bit per cycle; quotient known below 2^24.
// ----------------------------------------------------------------------------
module ird_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  dividend,
	input  logic [15:0]  divisor,
	output logic         done,
	output logic [23:0]  quotient
);
	localparam int STEPS = 24;
	localparam int SW = $clog2(STEPS);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [15:0]   rem_q;
	logic [23:0]   sh_q;
	logic [15:0]   dvs_q;
	logic [16:0]   trial;
	logic [16:0]   diff;
	logic          ge;

	assign trial = {rem_q, sh_q[23]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[31:16];
			sh_q  <= {dividend[15:0], 8'b0};
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			sh_q  <= {sh_q[22:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// ===== rtl/core/ird_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ird_back
// Table storage and conversion sequencer: clamp checks, segment walk,
// weighted sum and serial divide, with the output register.
// ----------------------------------------------------------------------------
module ird_back #(
	parameter int TABLE_DEPTH = ird_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ird_pkg::entry_t   head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [23:0]       distance,
	output logic              status
);
	import ird_pkg::*;

	localparam int TAW  = $clog2(4 * TABLE_DEPTH);
	localparam int DAW  = $clog2(2 * TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH);
	localparam int LAST = TABLE_DEPTH - 1;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_T0     = 10'b00_0000_0010,
		S_TL     = 10'b00_0000_0100,
		S_WALK   = 10'b00_0000_1000,
		S_D0     = 10'b00_0001_0000,
		S_D1     = 10'b00_0010_0000,
		S_SUM    = 10'b00_0100_0000,
		S_DIV    = 10'b00_1000_0000,
		S_DCLAMP = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [15:0] thr_mem [4 * TABLE_DEPTH];
	logic [15:0] dist_mem [2 * TABLE_DEPTH];
	logic [15:0] thr_rd_q;
	logic [15:0] dist_rd_q;

	logic [TAW-1:0] thr_raddr;
	logic [TAW-1:0] thr_waddr;
	logic [DAW-1:0] dist_raddr;
	logic [DAW-1:0] dist_waddr;
	logic           thr_we;
	logic           dist_we;

	logic [TAW-1:0]     tbase_q;
	logic [DAW-1:0]     dbase_q;
	logic signed [16:0] vx_q;
	logic signed [16:0] tprev_q;
	logic [CW-1:0]      c_q;
	logic [15:0]        m_q;
	logic [11:0]        n_q;
	logic [15:0]        den_q;
	logic [27:0]        prod_q;
	logic [31:0]        prod2_q;
	logic [23:0]        res_dist_q;
	logic               res_stat_q;
	logic               out_valid_q;
	logic [23:0]        distance_q;
	logic               status_q;

	logic signed [16:0] tcur;
	logic signed [16:0] diff_m;
	logic signed [16:0] diff_n;
	logic [15:0]        diff_den;
	logic               in_seg;
	logic               div_start;
	logic               div_done;
	logic [23:0]        div_quot;
	logic [31:0]        wsum;
	logic               out_load;

	assign pop     = (state_q == S_IDLE) && !empty;
	assign thr_we  = pop && (head.kind == KIND_WR_THR);
	assign dist_we = pop && (head.kind == KIND_WR_DIST);

	assign thr_waddr  = TAW'(int'(head.table_select[1:0]) * TABLE_DEPTH
		+ int'(head.entry_index));
	assign dist_waddr = DAW'(int'(head.table_select[0]) * TABLE_DEPTH
		+ int'(head.entry_index));

	always_comb begin
		unique case (state_q)
			S_IDLE:  thr_raddr = TAW'(int'(head.sensor) * TABLE_DEPTH);
			S_T0:    thr_raddr = TAW'(int'(tbase_q) + LAST);
			S_TL:    thr_raddr = TAW'(int'(tbase_q) + 1);
			S_WALK:  thr_raddr = TAW'(int'(tbase_q) + int'(c_q) + 2);
			default: thr_raddr = tbase_q;
		endcase
		unique case (state_q)
			S_TL:    dist_raddr = DAW'(int'(dbase_q) + LAST);
			S_WALK:  dist_raddr = DAW'(int'(dbase_q) + int'(c_q));
			S_D0:    dist_raddr = DAW'(int'(dbase_q) + int'(c_q) + 1);
			default: dist_raddr = dbase_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (thr_we) begin
			thr_mem[thr_waddr] <= head.entry_value;
		end
		thr_rd_q <= thr_mem[thr_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= head.entry_value;
		end
		dist_rd_q <= dist_mem[dist_raddr];
	end

	assign tcur     = $signed({1'b0, thr_rd_q});
	assign diff_m   = tprev_q - vx_q;
	assign diff_n   = vx_q - tcur;
	assign diff_den = tprev_q[15:0] - thr_rd_q;
	assign in_seg   = (vx_q <= tprev_q) && (vx_q > tcur);
	assign wsum     = {4'b0, prod_q} + prod2_q;
	assign div_start = (state_q == S_SUM);

	ird_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				tbase_q <= TAW'(int'(head.sensor) * TABLE_DEPTH);
				// sensors 0 and 1 are front, 2 and 3 side
				dbase_q <= head.sensor[1] ? DAW'(TABLE_DEPTH) : '0;
				vx_q    <= $signed({{4{head.reading[12]}}, head.reading});
			end
			S_T0: begin
				tprev_q <= tcur;
			end
			S_TL: begin
				c_q <= '0;
			end
			S_WALK: begin
				if (in_seg) begin
					m_q   <= diff_m[15:0];
					n_q   <= diff_n[11:0];
					den_q <= diff_den;
				end else if (c_q == CW'(LAST - 1)) begin
					res_dist_q <= '0;
					res_stat_q <= STATUS_NOSEG;
				end else begin
					tprev_q <= tcur;
					c_q     <= c_q + 1'b1;
				end
			end
			S_D0: begin
				prod_q <= 28'(n_q) * 28'(dist_rd_q);
			end
			S_D1: begin
				prod2_q <= 32'(m_q) * 32'(dist_rd_q);
			end
			S_DIV: begin
				res_dist_q <= div_quot;
				res_stat_q <= STATUS_OK;
			end
			S_DCLAMP: begin
				res_dist_q <= {dist_rd_q, 8'b0};
				res_stat_q <= STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop && head.kind == KIND_CONVERT) begin
						state_q <= S_T0;
					end
				end
				S_T0:     state_q <= (vx_q >= tcur) ? S_DCLAMP : S_TL;
				S_TL:     state_q <= (vx_q <= tcur) ? S_DCLAMP : S_WALK;
				S_WALK: begin
					if (in_seg) begin
						state_q <= S_D0;
					end else if (c_q == CW'(LAST - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_D0:     state_q <= S_D1;
				S_D1:     state_q <= S_SUM;
				S_SUM:    state_q <= S_DIV;
				S_DIV:    state_q <= div_done ? S_OUT : S_DIV;
				S_DCLAMP: state_q <= S_OUT;
				S_OUT:    state_q <= out_load ? S_IDLE : S_OUT;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (out_load) begin
			distance_q <= res_dist_q;
			status_q   <= res_stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign status    = status_q;

	a_seg_weights: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_D0 |-> ({1'b0, den_q} == {1'b0, m_q} + {5'b0, n_q}) && den_q != '0)
		else $error("segment weights inconsistent with span");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> int'(c_q) < LAST)
		else $error("segment index past last segment");

endmodule

// ===== rtl/core/ir_distance_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_distance_interpolator
// IR reading to distance converter by piecewise linear table interpolation.
//
// Input channel (in_valid/in_ready): operation 0 writes one table entry
// (table_select, entry_index, entry_value), operation 1 converts a reading
// of the given sensor. Writes give no output; each conversion gives one
// output transaction (distance with 8 fraction bits, status).
// Transactions enter a four-entry queue and are executed in order, so input
// is taken while the converter is busy or the output is stalled; in_ready
// drops only while the queue is full.
// A conversion with the back end idle either clamps to the first or the last
// distance, ends when no segment matches, or interpolates in segment k (k
// from 0) by the segment walk (one threshold read per cycle) and the serial
// divider. The back end takes no new transaction until a conversion is
// through. A table write is executed by the back end from its idle state.
// The output register holds a result until out_ready; while it is full the
// next result waits in the sequencer and the queue keeps filling.
// Reset clears control state only; table contents are undefined until written.
// ----------------------------------------------------------------------------
module ir_distance_interpolator #(
	parameter int TABLE_DEPTH = ird_pkg::TABLE_DEPTH_DEF,
	parameter int QUEUE_DEPTH = ird_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         operation,
	input  logic [2:0]   table_select,
	input  logic [3:0]   entry_index,
	input  logic [15:0]  entry_value,
	input  logic [1:0]   sensor,
	input  logic [12:0]  reading,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [23:0]  distance,
	output logic         status
);
	import ird_pkg::*;

	entry_t push_data;
	entry_t head;
	logic   push;
	logic   full;
	logic   pop;
	logic   empty;

	ird_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.table_select (table_select),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.sensor       (sensor),
		.reading      (reading),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	ird_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	ird_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance),
		.status    (status)
	);

endmodule
